// ===== src/swdik_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swdik_pkg
// Shared types, constants and fixed-point helpers for the swerve drive block.
// ----------------------------------------------------------------------------
package swdik_pkg;

  localparam int SPD_W   = 29;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_LENGTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_RADIUS  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED   = 8'd3;

  localparam logic [SPD_W-1:0]  DEADBAND      = 29'd1310;
  localparam logic signed [25:0] HALF_TURN    = 26'sd46080;
  localparam logic signed [25:0] QUARTER_Q16  = 26'sd5898240;
  localparam logic signed [33:0] GAIN_INV_Q30 = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;

  typedef struct packed {
    logic [19:0] half_length;
    logic [19:0] half_width;
    logic [23:0] inv_radius;
    logic [22:0] max_speed;
  } cfg_t;

  typedef struct packed {
    logic [3:0][SPD_W-1:0] spd;
    logic [3:0][23:0]      head;
    logic [3:0]            moving;
    logic [3:0][23:0]      cur;
    logic [SPD_W-1:0]      top;
  } item_t;

  typedef struct packed {
    logic [1:0]  wheel;
    logic [23:0] angle;
    logic [23:0] lin;
    logic [23:0] ang;
    logic        last;
  } res_t;

  function automatic logic signed [25:0] atan_q16(input logic [3:0] i);
    case (i)
      4'd0:    atan_q16 = 26'sd2949120;
      4'd1:    atan_q16 = 26'sd1740967;
      4'd2:    atan_q16 = 26'sd919879;
      4'd3:    atan_q16 = 26'sd466945;
      4'd4:    atan_q16 = 26'sd234379;
      4'd5:    atan_q16 = 26'sd117304;
      4'd6:    atan_q16 = 26'sd58666;
      4'd7:    atan_q16 = 26'sd29335;
      4'd8:    atan_q16 = 26'sd14668;
      4'd9:    atan_q16 = 26'sd7334;
      4'd10:   atan_q16 = 26'sd3667;
      4'd11:   atan_q16 = 26'sd1833;
      4'd12:   atan_q16 = 26'sd917;
      4'd13:   atan_q16 = 26'sd458;
      4'd14:   atan_q16 = 26'sd229;
      default: atan_q16 = 26'sd115;
    endcase
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
    if (v > 40'sd8388607)       sat24 = 24'sh7FFFFF;
    else if (v < -40'sd8388608) sat24 = 24'sh800000;
    else                        sat24 = v[23:0];
  endfunction

  // wrap into [-180,180] deg, Q.8; 92160 = 45 * 2^11
  function automatic logic signed [17:0] wrap_deg(input logic signed [25:0] a);
    logic signed [27:0] s;
    logic [26:0] u;
    logic [15:0] v;
    logic [26:0] p;
    logic [10:0] q;
    logic [16:0] qm;
    logic [16:0] rr;
    logic [16:0] r;
    s  = 28'(a) + 28'sd33638400;
    u  = s[26:0];
    v  = u[26:11];
    p  = 27'(v) * 27'd1456;
    q  = p[26:16];
    qm = 17'(q) * 17'd45;
    rr = 17'(v) - qm;
    if (rr >= 17'd45) rr = rr - 17'd45;
    r  = {rr[5:0], u[10:0]};
    if (r > 17'd46080)                    wrap_deg = 18'(r) - 18'sd92160;
    else if (r == 17'd46080 && a < 26'sd0) wrap_deg = -18'sd46080;
    else                                   wrap_deg = 18'(r);
  endfunction

endpackage

// ===== src/swerve_drive_inverse_kinematics.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swerve_drive_inverse_kinematics
// Four-wheel swerve inverse kinematics, fixed point, four results per command.
// ----------------------------------------------------------------------------
// Front end: a 29-step root with the heading CORDIC, per wheel. Back end, per
// wheel: the 23-step divider and the 16-step cosine CORDIC. A queue between
// them lets the front end take a new command while the back end works.
// rst (synchronous) clears queues, state machines and held angles, and loads
// the register reset values.
module swerve_drive_inverse_kinematics
  import swdik_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 2,
  parameter int RESULT_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic signed [23:0]   vel_x,
  input  logic signed [23:0]   vel_y,
  input  logic signed [23:0]   yaw_rate,
  input  logic signed [23:0]   current_angle_w0,
  input  logic signed [23:0]   current_angle_w1,
  input  logic signed [23:0]   current_angle_w2,
  input  logic signed [23:0]   current_angle_w3,
  output logic                 empty,
  input  logic                 pop,
  output logic [1:0]           wheel_index,
  output logic signed [23:0]   target_angle,
  output logic signed [23:0]   target_linear_speed,
  output logic signed [23:0]   target_angular_speed,
  output logic                 last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [23:0]          cfg_data
);

  cfg_t            cfg;
  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;
  item_t           q_wr;
  item_t           q_rd;
  logic            o_push;
  logic            o_full;
  res_t            o_wr;
  res_t            o_rd;
  logic [3:0][23:0] cur_angle;

  assign cfg_ready = 1'b1;
  assign cur_angle = {current_angle_w3, current_angle_w2,
                      current_angle_w1, current_angle_w0};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_length <= 20'd13107;
      cfg.half_width  <= 20'd13107;
      cfg.inv_radius  <= 24'd1310720;
      cfg.max_speed   <= 23'd262144;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HALF_LENGTH: cfg.half_length <= cfg_data[19:0];
        REG_HALF_WIDTH:  cfg.half_width  <= cfg_data[19:0];
        REG_INV_RADIUS:  cfg.inv_radius  <= cfg_data;
        REG_MAX_SPEED:   cfg.max_speed   <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

  swdik_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .full      (full),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .yaw_rate  (yaw_rate),
    .cur_angle (cur_angle),
    .q_push    (q_push),
    .q_full    (q_full),
    .q_item    (q_wr)
  );

  swdik_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .full  (q_full),
    .wdata (q_wr),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rd)
  );

  swdik_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_item  (q_rd),
    .o_push  (o_push),
    .o_full  (o_full),
    .o_res   (o_wr)
  );

  swdik_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_results (
    .clk   (clk),
    .rst   (rst),
    .push  (o_push),
    .full  (o_full),
    .wdata (o_wr),
    .pop   (pop),
    .empty (empty),
    .rdata (o_rd)
  );

  assign wheel_index          = o_rd.wheel;
  assign target_angle         = o_rd.angle;
  assign target_linear_speed  = o_rd.lin;
  assign target_angular_speed = o_rd.ang;
  assign last                 = o_rd.last;

endmodule

// ===== src/swdik_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swdik_fifo
// Small synchronous queue of words.
// ----------------------------------------------------------------------------
module swdik_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue fill beyond depth");

endmodule

// ===== src/swdik_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swdik_front
// Takes a command, forms each wheel's velocity, speed (bit-serial root) and
// heading (CORDIC vectoring), and queues the finished word for the back end.
// ----------------------------------------------------------------------------
module swdik_front
  import swdik_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic                    push,
  output logic                    full,
  input  logic signed [23:0]      vel_x,
  input  logic signed [23:0]      vel_y,
  input  logic signed [23:0]      yaw_rate,
  input  logic [3:0][23:0]        cur_angle,
  output logic                    q_push,
  input  logic                    q_full,
  output item_t                   q_item
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_WA    = 4'd1;
  localparam logic [3:0] ST_WB    = 4'd2;
  localparam logic [3:0] ST_TXY   = 4'd3;
  localparam logic [3:0] ST_SQX   = 4'd4;
  localparam logic [3:0] ST_SQY   = 4'd5;
  localparam logic [3:0] ST_SUM   = 4'd6;
  localparam logic [3:0] ST_RUN   = 4'd7;
  localparam logic [3:0] ST_STORE = 4'd8;
  localparam logic [3:0] ST_PUSH  = 4'd9;

  logic [3:0]         state;
  logic signed [23:0] vx;
  logic signed [23:0] vy;
  logic signed [23:0] wz;
  logic signed [29:0] wa;
  logic signed [29:0] wb;
  logic [1:0]         wheel;
  logic signed [30:0] tx;
  logic signed [30:0] ty;
  logic [57:0]        px;
  logic [57:0]        py;
  logic [57:0]        sq_v;
  logic [57:0]        sq_res;
  logic [57:0]        sq_bit;
  logic signed [33:0] cx;
  logic signed [33:0] cy;
  logic signed [25:0] cz;
  logic [4:0]         step;
  item_t              item;

  logic [19:0]        hsel;
  logic signed [44:0] wprod;
  logic [44:0]        wmag;
  logic [28:0]        wrnd;
  logic signed [29:0] wround;
  logic signed [30:0] sq_op;
  logic signed [61:0] sq_prod;
  logic [57:0]        sq_t;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic [25:0]        zmag;
  logic [17:0]        hrnd;
  logic [SPD_W-1:0]   spd_now;

  always_comb begin
    hsel    = (state == ST_WA) ? cfg.half_length : cfg.half_width;
    wprod   = wz * $signed({1'b0, hsel});
    wmag    = wprod[44] ? 45'(-wprod) : 45'(wprod);
    wrnd    = 29'((wmag + 45'd32768) >> 16);
    wround  = wprod[44] ? -$signed({1'b0, wrnd}) : $signed({1'b0, wrnd});
    sq_op   = (state == ST_SQX) ? tx : ty;
    sq_prod = sq_op * sq_op;
    sq_t    = sq_res + sq_bit;
    xs      = cx >>> step[3:0];
    ys      = cy >>> step[3:0];
    zmag    = cz[25] ? 26'(-cz) : 26'(cz);
    hrnd    = 18'((zmag + 26'd128) >> 8);
    spd_now = sq_res[SPD_W-1:0];
  end

  assign full   = (state != ST_IDLE);
  assign q_push = (state == ST_PUSH) && !q_full;
  assign q_item = item;

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (push) begin
          vx       <= vel_x;
          vy       <= vel_y;
          wz       <= yaw_rate;
          item.cur <= cur_angle;
          item.top <= '0;
          wheel    <= '0;
        end
      end
      ST_WA: wa <= wround;
      ST_WB: wb <= wround;
      ST_TXY: begin
        tx <= (wheel[1]) ? 31'(vx) + 31'(wb) : 31'(vx) - 31'(wb);
        ty <= (wheel == 2'd1 || wheel == 2'd2) ? 31'(vy) - 31'(wa) : 31'(vy) + 31'(wa);
      end
      ST_SQX: px <= sq_prod[57:0];
      ST_SQY: py <= sq_prod[57:0];
      ST_SUM: begin
        sq_v   <= px + py;
        sq_res <= '0;
        sq_bit <= 58'd1 << 56;
        step   <= '0;
        if (tx < 0) begin
          if (ty >= 0) begin
            cx <= 34'(ty);
            cy <= -34'(tx);
            cz <= QUARTER_Q16;
          end else begin
            cx <= -34'(ty);
            cy <= 34'(tx);
            cz <= -QUARTER_Q16;
          end
        end else begin
          cx <= 34'(tx);
          cy <= 34'(ty);
          cz <= '0;
        end
      end
      ST_RUN: begin
        step <= step + 1'b1;
        if (sq_v >= sq_t) begin
          sq_v   <= sq_v - sq_t;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
        if (step < 5'd16) begin
          if (cy >= 0) begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + atan_q16(step[3:0]);
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - atan_q16(step[3:0]);
          end
        end
      end
      ST_STORE: begin
        item.spd[wheel]    <= spd_now;
        item.head[wheel]   <= cz[25] ? -24'(hrnd) : 24'(hrnd);
        item.moving[wheel] <= spd_now > DEADBAND;
        if (spd_now > item.top) begin
          item.top <= spd_now;
        end
        wheel <= wheel + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE:  if (push) state <= ST_WA;
        ST_WA:    state <= ST_WB;
        ST_WB:    state <= ST_TXY;
        ST_TXY:   state <= ST_SQX;
        ST_SQX:   state <= ST_SQY;
        ST_SQY:   state <= ST_SUM;
        ST_SUM:   state <= ST_RUN;
        ST_RUN:   if (step == 5'd28) state <= ST_STORE;
        ST_STORE: state <= (wheel == 2'd3) ? ST_PUSH : ST_TXY;
        ST_PUSH:  if (!q_full) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  a_top_covers: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (item.top >= item.spd[0] && item.top >= item.spd[1] &&
                item.top >= item.spd[2] && item.top >= item.spd[3]))
    else $error("queued peak speed below a wheel speed");

  a_moving_deadband: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (item.moving[0] == (item.spd[0] > DEADBAND)))
    else $error("moving flag disagrees with speed");

endmodule

// ===== src/swdik_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swdik_back
// Per wheel: scales the speed (shared divider), picks the shorter turn,
// runs the cosine CORDIC and forms linear and angular speed.
// ----------------------------------------------------------------------------
module swdik_back
  import swdik_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  q_empty,
  output logic  q_pop,
  input  item_t q_item,
  output logic  o_push,
  input  logic  o_full,
  output res_t  o_res
);

  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_LOAD  = 4'd1;
  localparam logic [3:0] B_MUL   = 4'd2;
  localparam logic [3:0] B_DIV   = 4'd3;
  localparam logic [3:0] B_CHK   = 4'd4;
  localparam logic [3:0] B_WRAP1 = 4'd5;
  localparam logic [3:0] B_WRAP2 = 4'd6;
  localparam logic [3:0] B_PICK  = 4'd7;
  localparam logic [3:0] B_COS   = 4'd8;
  localparam logic [3:0] B_LIN   = 4'd9;
  localparam logic [3:0] B_ANG   = 4'd10;
  localparam logic [3:0] B_EMIT  = 4'd11;

  logic [3:0]         state;
  item_t              item;
  logic [1:0]         wheel;
  logic signed [23:0] held [4];
  logic signed [23:0] raw;
  logic [22:0]        spd_s;
  logic [SPD_W-1:0]   rem;
  logic [22:0]        numlo;
  logic [4:0]         step;
  logic signed [17:0] d1;
  logic signed [17:0] d2;
  logic               flip;
  logic signed [33:0] cx;
  logic signed [33:0] cy;
  logic signed [25:0] cz;
  logic signed [24:0] linr;
  logic signed [23:0] ang;

  logic signed [23:0] cur;
  logic signed [23:0] raw_now;
  logic [51:0]        num;
  logic [SPD_W:0]     rem2;
  logic [17:0]        a1;
  logic [17:0]        a2;
  logic               flip_now;
  logic signed [17:0] dsel;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic [30:0]        cosv;
  logic [53:0]        lprod;
  logic [23:0]        linm;
  logic signed [49:0] aprod;
  logic [49:0]        amag;
  logic [33:0]        arnd;
  logic signed [39:0] aval;

  always_comb begin
    cur      = $signed(item.cur[wheel]);
    raw_now  = item.moving[wheel] ? $signed(item.head[wheel]) : held[wheel];
    num      = 52'(item.spd[wheel]) * 52'(cfg.max_speed);
    rem2     = {rem, numlo[22]};
    a1       = d1[17] ? 18'(-d1) : 18'(d1);
    a2       = d2[17] ? 18'(-d2) : 18'(d2);
    flip_now = !(a1 < a2);
    dsel     = flip_now ? d2 : d1;
    xs       = cx >>> step[3:0];
    ys       = cy >>> step[3:0];
    if (cx < 0)            cosv = '0;
    else if (cx > ONE_Q30) cosv = 31'(ONE_Q30);
    else                   cosv = cx[30:0];
    lprod    = 54'(spd_s) * 54'(cosv);
    linm     = 24'((lprod + 54'd536870912) >> 30);
    aprod    = linr * $signed({1'b0, cfg.inv_radius});
    amag     = aprod[49] ? 50'(-aprod) : 50'(aprod);
    arnd     = 34'((amag + 50'd32768) >> 16);
    aval     = aprod[49] ? -40'(arnd) : 40'(arnd);
  end

  assign q_pop       = (state == B_IDLE) && !q_empty;
  assign o_push      = (state == B_EMIT) && !o_full;
  assign o_res.wheel = wheel;
  assign o_res.angle = held[wheel];
  assign o_res.lin   = sat24(40'(linr));
  assign o_res.ang   = ang;
  assign o_res.last  = (wheel == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        held[i] <= '0;
      end
    end else if (state == B_LOAD) begin
      held[wheel] <= raw_now;
    end else if (state == B_PICK) begin
      held[wheel] <= sat24(40'(25'(cur) + 25'(dsel)));
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          item  <= q_item;
          wheel <= '0;
        end
      end
      B_LOAD: begin
        raw   <= raw_now;
        spd_s <= item.spd[wheel][22:0];
      end
      B_MUL: begin
        rem   <= num[51:23];
        numlo <= num[22:0];
        spd_s <= '0;
        step  <= '0;
      end
      B_DIV: begin
        step  <= step + 1'b1;
        numlo <= numlo << 1;
        if (rem2 >= {1'b0, item.top}) begin
          rem   <= SPD_W'(rem2 - {1'b0, item.top});
          spd_s <= {spd_s[21:0], 1'b1};
        end else begin
          rem   <= rem2[SPD_W-1:0];
          spd_s <= {spd_s[21:0], 1'b0};
        end
      end
      B_CHK: begin
        linr <= '0;
        ang  <= '0;
      end
      B_WRAP1: d1 <= wrap_deg(26'(raw) - 26'(cur));
      B_WRAP2: d2 <= wrap_deg(26'(raw) + HALF_TURN - 26'(cur));
      B_PICK: begin
        flip <= flip_now;
        cx   <= GAIN_INV_Q30;
        cy   <= '0;
        cz   <= 26'(dsel) <<< 8;
        step <= '0;
      end
      B_COS: begin
        step <= step + 1'b1;
        if (cz >= 0) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - atan_q16(step[3:0]);
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + atan_q16(step[3:0]);
        end
      end
      B_LIN: linr <= flip ? -$signed({1'b0, linm}) : $signed({1'b0, linm});
      B_ANG: ang  <= sat24(aval);
      B_EMIT: if (!o_full) wheel <= wheel + 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE:  if (!q_empty) state <= B_LOAD;
        B_LOAD:  state <= (item.top > SPD_W'(cfg.max_speed)) ? B_MUL : B_CHK;
        B_MUL:   state <= B_DIV;
        B_DIV:   if (step == 5'd22) state <= B_CHK;
        B_CHK:   state <= ({6'd0, spd_s} > DEADBAND) ? B_WRAP1 : B_EMIT;
        B_WRAP1: state <= B_WRAP2;
        B_WRAP2: state <= B_PICK;
        B_PICK:  state <= B_COS;
        B_COS:   if (step == 5'd15) state <= B_LIN;
        B_LIN:   state <= B_ANG;
        B_ANG:   state <= B_EMIT;
        B_EMIT:  if (!o_full) state <= (wheel == 2'd3) ? B_IDLE : B_LOAD;
        default: state <= B_IDLE;
      endcase
    end
  end

  a_last_on_wheel3: assert property (@(posedge clk) disable iff (rst)
    o_push |-> (o_res.last == (o_res.wheel == 2'd3)))
    else $error("last flag not on the fourth wheel");

  a_scaled_limit: assert property (@(posedge clk) disable iff (rst)
    (state == B_CHK) |-> (spd_s <= cfg.max_speed || item.top <= SPD_W'(cfg.max_speed)))
    else $error("scaled speed above limit");

  a_idle_speed_zero: assert property (@(posedge clk) disable iff (rst)
    (o_push && ({6'd0, spd_s} <= DEADBAND)) |-> (linr == 0 && ang == 0))
    else $error("standing wheel with non-zero speed");

endmodule
